// ===== hw/rtl/lsbc_pkg.sv =====
package lsbc_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_COUNT = 8'd1;

  // Mode codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int unsigned SYM_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACC_W   = 12;
  localparam int unsigned HELD_W  = 4;
  localparam int unsigned COUNT_W = 24;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Stream state carried from one word to the next.
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [HELD_W-1:0] held;
    count_t            emitted;
  } stream_state_t;

  // Results produced by one input word: count and up to two bytes.
  typedef struct packed {
    logic [1:0] num;
    byte_t      res0;
    byte_t      res1;
  } step_result_t;

  // Character code for a six-bit symbol index.
  function automatic byte_t sym_char(sym_t idx);
    byte_t c;
    c = 8'h2e;
    if (idx == 6'd0) begin
      c = 8'h2e;
    end else if (idx <= 6'd26) begin
      c = 8'(8'h41 + {2'b00, idx} - 8'd1);
    end else if (idx <= 6'd52) begin
      c = 8'(8'h61 + {2'b00, idx} - 8'd27);
    end else if (idx <= 6'd62) begin
      c = 8'(8'h30 + {2'b00, idx} - 8'd53);
    end else begin
      c = 8'h2b;
    end
    return c;
  endfunction

  // Symbol index of a character; bit 6 set when the character is in the alphabet.
  function automatic logic [SYM_W:0] sym_index(byte_t c);
    logic [SYM_W:0] r;
    r = '0;
    if (c == 8'h2e) begin
      r = {1'b1, 6'd0};
    end else if (c inside {[8'h41:8'h5a]}) begin
      r = {1'b1, 6'(c - 8'h41 + 8'd1)};
    end else if (c inside {[8'h61:8'h7a]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd27)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd53)};
    end else if (c == 8'h2b) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lsbc_step.sv =====
module lsbc_step (
  input  logic                   mode,
  input  lsbc_pkg::count_t       byte_count,
  input  lsbc_pkg::stream_state_t cur,
  input  lsbc_pkg::byte_t        value,
  input  logic                   last,
  output lsbc_pkg::stream_state_t nxt,
  output lsbc_pkg::step_result_t res
);
  import lsbc_pkg::*;

  logic [ACC_W-1:0]  enc_acc;
  logic [HELD_W-1:0] enc_held;
  logic              enc_full;
  logic [SYM_W:0]    dec_sym;
  logic [ACC_W-1:0]  dec_acc;
  logic [HELD_W-1:0] dec_held;
  logic              dec_full;
  logic              room0;
  logic              room1;
  logic [ACC_W-1:0]  dec_acc2;
  logic [HELD_W-1:0] dec_held2;
  count_t            emitted1;
  stream_state_t     st;

  // Encode: append the byte above the held bits and cut off six-bit symbols.
  assign enc_acc  = cur.acc | ACC_W'({4'b0000, value} << cur.held);
  assign enc_held = 4'(cur.held + 4'd8);
  assign enc_full = (enc_held >= 4'd12);

  // Decode: append the symbol index when the character is in the alphabet.
  assign dec_sym  = sym_index(value);
  assign dec_acc  = dec_sym[SYM_W] ? (cur.acc | ACC_W'({6'b0, dec_sym[SYM_W-1:0]} << cur.held))
                                   : cur.acc;
  assign dec_held = dec_sym[SYM_W] ? 4'(cur.held + 4'd6) : cur.held;
  assign dec_full = (dec_held >= 4'd8);
  assign room0    = (cur.emitted < byte_count);
  assign emitted1 = (dec_full && room0) ? 24'(cur.emitted + 24'd1) : cur.emitted;
  assign room1    = (emitted1 < byte_count);
  assign dec_acc2  = dec_full ? (dec_acc >> 8) : dec_acc;
  assign dec_held2 = dec_full ? 4'(dec_held - 4'd8) : dec_held;

  always_comb begin
    res = '0;
    st  = cur;
    if (mode == MODE_ENCODE) begin
      res.res0 = sym_char(enc_acc[5:0]);
      res.res1 = sym_char(enc_acc[11:6]);
      res.num  = (enc_full || last) ? 2'd2 : 2'd1;
      st.acc   = enc_full ? '0 : (enc_acc >> 6);
      st.held  = enc_full ? '0 : 4'(enc_held - 4'd6);
      st.emitted = '0;
    end else begin
      st.acc     = dec_acc2;
      st.held    = dec_held2;
      st.emitted = emitted1;
      if (dec_full && room0) begin
        res.res0 = dec_acc[7:0];
        res.num  = 2'd1;
        if (last && dec_held2 != '0 && room1) begin
          res.res1 = dec_acc2[7:0];
          res.num  = 2'd2;
        end
      end else if (last && dec_held2 != '0 && room1) begin
        res.res0 = dec_acc2[7:0];
        res.num  = 2'd1;
      end
    end
    // The end of a stream returns all state to zero.
    nxt = last ? '0 : st;
  end

endmodule

// ===== hw/rtl/lsb_first_six_bit_text_codec.sv =====
// An accepted word goes to the input register, its results to the result pair.
// Throughput: one input word per cycle while out_tready stays high and each word
// gives at most one result; two results hold the single result port until both leave.
// Reset (rst_n low, synchronous) clears mode, byte_count, the stream state
// and the valid flags of both the input and the result registers.
module lsb_first_six_bit_text_codec (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream: tdata = in_value[7:0]; tlast = in_last.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  input  logic                             in_tlast,
  // Result stream: tdata = out_value[7:0]; tlast = out_last.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,
  output logic                             out_tlast,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsbc_pkg::*;

  logic          mode_r;
  count_t        byte_count_r;
  stream_state_t state_r;
  stream_state_t state_nxt;
  step_result_t  step_res;

  logic          hold_valid_r;
  byte_t         hold_value_r;
  logic          hold_last_r;

  logic [1:0]    res_cnt_r;
  byte_t         res0_r;
  byte_t         res1_r;

  logic          in_fire;
  logic          out_fire;
  logic          cfg_fire;
  logic          buf_free;
  logic          proc;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = (res_cnt_r == 2'd0) || (res_cnt_r == 2'd1 && out_fire);
  assign proc      = hold_valid_r && buf_free;
  assign in_tready = !hold_valid_r || proc;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_ENCODE;
      byte_count_r <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == REG_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index == REG_BYTE_COUNT) begin
        byte_count_r <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_fire) begin
      hold_valid_r <= 1'b1;
    end else if (proc) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_value_r <= in_tdata;
      hold_last_r  <= in_tlast;
    end
  end

  lsbc_step u_step (
    .mode       (mode_r),
    .byte_count (byte_count_r),
    .cur        (state_r),
    .value      (hold_value_r),
    .last       (hold_last_r),
    .nxt        (state_nxt),
    .res        (step_res)
  );

  // Stream state; a write to mode starts a fresh stream.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (cfg_fire && cfg_index == REG_MODE) begin
      state_r <= '0;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  // Result register pair: the first word is shown, the second moves up after it leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else if (proc) begin
      res_cnt_r <= step_res.num;
    end else if (out_fire) begin
      res_cnt_r <= 2'(res_cnt_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res0_r <= step_res.res0;
      res1_r <= step_res.res1;
    end else if (out_fire) begin
      res0_r <= res1_r;
    end
  end

  assign out_tvalid = (res_cnt_r != 2'd0);
  assign out_tdata  = res0_r;
  assign out_tlast  = (res_cnt_r == 2'd1);

endmodule

// ===== bench/text_codec_check.sv =====
// Watches the three channels of the six-bit text codec, predicts every result word
// from the words accepted on the input and configuration channels, and compares.
module text_codec_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [7:0]                       in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [7:0]                       out_tdata,
  input  logic                             out_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lsbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               outstanding,
  output int                               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import lsbc_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } text_word_t;

  // Predicted copy of the codec's configuration and stream state.
  logic        cur_mode;
  logic [23:0] length_limit;
  logic [12:0] pending_bits;
  logic [3:0]  pending_count;
  logic [23:0] bytes_out;

  text_word_t  awaited_words[$];
  text_word_t  oldest;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  // Character for a six-bit symbol index.
  function automatic logic [7:0] symbol_char(input logic [5:0] k);
    if (k == 6'd0) return 8'h2e;
    if (k <= 6'd26) return 8'(8'h41 + {2'b00, k} - 8'd1);
    if (k <= 6'd52) return 8'(8'h61 + {2'b00, k} - 8'd27);
    if (k <= 6'd62) return 8'(8'h30 + {2'b00, k} - 8'd53);
    return 8'h2b;
  endfunction

  // Symbol index of a character, or -1 when it is outside the alphabet.
  function automatic int char_symbol(input logic [7:0] c);
    if (c == 8'h2e) return 0;
    if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 'h41 + 1;
    if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h61 + 27;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 53;
    if (c == 8'h2b) return 63;
    return -1;
  endfunction

  task automatic clear_stream();
    pending_bits  = '0;
    pending_count = '0;
    bytes_out     = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // Works out the result words that one input word causes and queues them.
  task automatic predict_word(input logic [7:0] v, input logic l);
    text_word_t res[2];
    int         n;
    int         k;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (cur_mode == MODE_ENCODE) begin
      pending_bits  = pending_bits | (13'(v) << pending_count);
      pending_count = pending_count + 4'd8;
      while (pending_count >= 4'd6 && n < 2) begin
        res[n].value = symbol_char(pending_bits[5:0]);
        n++;
        pending_bits  = pending_bits >> 6;
        pending_count = pending_count - 4'd6;
      end
      if (l && pending_count > 0 && n < 2) begin
        res[n].value = symbol_char(pending_bits[5:0]);
        n++;
      end
    end else begin
      k = char_symbol(v);
      if (k >= 0) begin
        pending_bits  = pending_bits | (13'(k) << pending_count);
        pending_count = pending_count + 4'd6;
        if (pending_count >= 4'd8) begin
          if (bytes_out < length_limit) begin
            res[n].value = pending_bits[7:0];
            n++;
            bytes_out++;
          end
          pending_bits  = pending_bits >> 8;
          pending_count = pending_count - 4'd8;
        end
      end
      // A flush of the partial byte obeys the same length limit.
      if (l && pending_count > 0 && bytes_out < length_limit && n < 2) begin
        res[n].value = pending_bits[7:0];
        n++;
        bytes_out++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_words.push_back(res[i]);
    if (l) clear_stream();
  endtask

  // Result words are checked before the same edge's input is predicted, so that
  // a word can only match an expectation queued at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode     = MODE_ENCODE;
      length_limit = '0;
      clear_stream();
      awaited_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("result word with nothing expected", 8'h00, out_tdata);
        end else begin
          oldest = awaited_words.pop_front();
          if (out_tdata !== oldest.value)
            report_mismatch("out_tdata", oldest.value, out_tdata);
          if (out_tlast !== oldest.last)
            report_mismatch("out_tlast", {7'd0, oldest.last}, {7'd0, out_tlast});
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODE) begin
          cur_mode = cfg_data[0];
          clear_stream();
        end else if (cfg_index == REG_BYTE_COUNT) begin
          length_limit = cfg_data;
        end
      end
      if (in_tvalid && in_tready) predict_word(in_tdata, in_tlast);
    end
    outstanding = awaited_words.size();
  end

endmodule

// ===== bench/lsb_first_six_bit_text_codec_test.sv =====
// Drives the codec with directed and random streams in both modes and gives the verdict.
module lsb_first_six_bit_text_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsbc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 4;
  localparam int DRAIN       = 20;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [7:0]             out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int outstanding;
  int mismatches;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int streams_sent  = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  bit long_hold_req = 1'b0;

  lsb_first_six_bit_text_codec uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  text_codec_check codec_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #5 clk = ~clk;

  // Give up on a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one input word after a random gap and returns once it is taken.
  task automatic push_word(input logic [7:0] v, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Waits until every expected word has come out, then waits on so that a word
  // that gives no result can also pass through.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [7:0] alphabet_char();
    case ($urandom_range(3))
      0:       return 8'(8'h41 + $urandom_range(25));
      1:       return 8'(8'h61 + $urandom_range(25));
      2:       return 8'(8'h30 + $urandom_range(9));
      default: return $urandom_range(1) ? 8'h2e : 8'h2b;
    endcase
  endfunction

  // Mostly short limits so that the limit is often reached, with the extremes.
  function automatic logic [23:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return 24'd0;
    if (pick < 15) return 24'hffffff;
    if (pick < 75) return 24'($urandom_range(1, 8));
    return 24'($urandom);
  endfunction

  // Decode streams are mostly alphabet characters with some noise bytes.
  task automatic send_stream(input logic mode_sel, input int len, input bit with_last);
    logic [7:0] v;
    bit         noise;
    for (int i = 0; i < len; i++) begin
      noise = 1'b0;
      if (mode_sel == MODE_DECODE) begin
        noise = ($urandom_range(9) == 0);
        v     = noise ? 8'($urandom_range(255)) : alphabet_char();
      end else begin
        v = 8'($urandom_range(255));
      end
      push_word(v, with_last && (i == len - 1));
    end
    streams_sent++;
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int target);
    int                    first;
    int                    len;
    logic                  mode_sel;
    logic [CFG_DATA_W-1:0] mode_word;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first         = items_sent;
    while (items_sent - first < target) begin
      mode_sel     = $urandom_range(1) ? MODE_DECODE : MODE_ENCODE;
      mode_word    = 24'($urandom);
      mode_word[0] = mode_sel;
      write_reg(REG_MODE, mode_word);
      if (mode_sel == MODE_DECODE) write_reg(REG_BYTE_COUNT, random_count());
      // Writes to an index past the register list must change nothing.
      if ($urandom_range(9) == 0) write_reg(8'($urandom_range(2, 255)), 24'($urandom));
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        if (mode_sel == MODE_DECODE && len > 1 && $urandom_range(4) == 0) begin
          // A new length limit part-way through a stream; the stream carries on.
          send_stream(mode_sel, len / 2, 1'b0);
          write_reg(REG_BYTE_COUNT, random_count());
          send_stream(mode_sel, len - len / 2, $urandom_range(9) != 0);
        end else begin
          send_stream(mode_sel, len, $urandom_range(9) != 0);
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Encode after reset: zero byte with flush, a run ending on a full group,
    // and a four-bit remainder that needs padding.
    push_word(8'h00, 1'b1);
    push_word(8'hff, 1'b0);
    push_word(8'hff, 1'b0);
    push_word(8'hff, 1'b1);
    push_word(8'ha5, 1'b0);
    push_word(8'h5a, 1'b1);

    write_reg(8'hff, 24'hffffff);
    write_reg(REG_MODE, {23'h7fffff, MODE_DECODE});
    write_reg(REG_BYTE_COUNT, 24'hffffff);

    // Decode: the alphabet's boundary characters, then noise that ends the stream.
    push_word(".", 1'b0);
    push_word("+", 1'b0);
    push_word("A", 1'b0);
    push_word("Z", 1'b0);
    push_word("a", 1'b0);
    push_word("z", 1'b0);
    push_word("0", 1'b0);
    push_word("9", 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b1);

    // Bytes beyond the length limit are dropped, and so is the flush.
    write_reg(REG_BYTE_COUNT, 24'd1);
    push_word("+", 1'b0);
    push_word("+", 1'b0);
    push_word("+", 1'b0);
    push_word("@", 1'b1);

    write_reg(REG_BYTE_COUNT, 24'd0);
    push_word("Q", 1'b0);
    push_word("w", 1'b1);

    // Raising the limit mid-stream keeps the pending bits.
    write_reg(REG_BYTE_COUNT, 24'd2);
    push_word("k", 1'b0);
    push_word("k", 1'b0);
    write_reg(REG_BYTE_COUNT, 24'd3);
    push_word("5", 1'b1);

    write_reg(REG_MODE, {23'h0, MODE_ENCODE});

    run_phase(16, 67, 530);
    run_phase(67, 16, 530);

    // The result side holds off while input keeps coming, so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_MODE, {23'h0, MODE_ENCODE});
    long_hold_req = 1'b1;
    send_stream(MODE_ENCODE, 40, 1'b1);

    run_phase(0, 0, 530);

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Sent %0d input words in %0d streams with %0d register writes,",
             items_sent, streams_sent, reg_writes);
    $display("covering both modes, length limits and three patterns of idling.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
